// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/dpu_pkg.sv -----
package dpu_pkg;

	localparam int VPAGES     = 8;
	localparam int FRAMES     = 4;
	localparam int PAGE_WORDS = 8;
	localparam int DATA_W     = 32;

	localparam int PAGE_W     = $clog2(VPAGES);
	localparam int FRAME_W    = $clog2(FRAMES);
	localparam int OFF_W      = $clog2(PAGE_WORDS);
	localparam int VADDR_W    = PAGE_W + OFF_W;
	localparam int MAIN_WORDS = FRAMES * PAGE_WORDS;
	localparam int BACK_WORDS = VPAGES * PAGE_WORDS;
	localparam int MADDR_W    = $clog2(MAIN_WORDS);
	localparam int BADDR_W    = $clog2(BACK_WORDS);
	localparam int CNT_W      = OFF_W + 1;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef logic [PAGE_W-1:0]        page_t;
	typedef logic [FRAME_W-1:0]       frame_t;
	typedef logic [OFF_W-1:0]         off_t;
	typedef logic [VADDR_W-1:0]       vaddr_t;
	typedef logic [MADDR_W-1:0]       maddr_t;
	typedef logic [BADDR_W-1:0]       baddr_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	localparam logic KIND_READ   = 1'b0;
	localparam logic KIND_WRITE  = 1'b1;
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_LRU  = 1'b1;

endpackage

// ----- hw/rtl/demand_paging_unit_core.sv -----
// Channel   Handshake               Payload
// request   start in, busy out      kind, virtual_address, write_value
// result    done out (1 cycle)      read_value, page_fault
// config    cfg_we in               cfg_wdata (replacement policy)
//
// A hit write passes through LOOKUP and ACCESS, a hit read also through READ; a fault
// adds LOAD, which loads the page over the backing store read port, and WB before it
// to write back a dirty victim over the main store read port.
// Reset clears the page table, LRU ages, FIFO pointer and the store valid bits;
// never-written store words read as all ones. The receiver cannot stall: done
// pulses for one cycle as busy drops, and a new beat may be started then.
module demand_paging_unit_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   kind,
	input  dpu_pkg::vaddr_t        virtual_address,
	input  dpu_pkg::word_t         write_value,
	output logic                   done,
	output dpu_pkg::word_t         read_value,
	output logic                   page_fault,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOKUP = 3'd1;
	localparam logic [2:0] ST_WB     = 3'd2;
	localparam logic [2:0] ST_LOAD   = 3'd3;
	localparam logic [2:0] ST_ACCESS = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;

	logic [2:0]              state_q;
	logic                    policy_q;
	logic                    kind_q;
	dpu_pkg::page_t          page_q;
	dpu_pkg::off_t           off_q;
	dpu_pkg::word_t          wdata_q;
	dpu_pkg::frame_t         fr_q;
	dpu_pkg::page_t          vp_q;
	logic                    fault_q;
	dpu_pkg::cnt_t           cnt_q;
	dpu_pkg::frame_t         fifo_ptr_q;

	logic [dpu_pkg::VPAGES-1:0] entry_valid_q;
	logic [dpu_pkg::VPAGES-1:0] entry_dirty_q;
	dpu_pkg::frame_t            entry_frame_q [dpu_pkg::VPAGES];
	logic [dpu_pkg::FRAMES-1:0] frame_used_q;
	dpu_pkg::frame_t            frame_age_q [dpu_pkg::FRAMES];

	logic                    done_q;
	dpu_pkg::word_t          read_value_q;
	logic                    page_fault_q;

	// stores and their valid bits
	dpu_pkg::word_t                  main_mem [dpu_pkg::MAIN_WORDS];
	dpu_pkg::word_t                  back_mem [dpu_pkg::BACK_WORDS];
	logic [dpu_pkg::MAIN_WORDS-1:0]  main_vld_q;
	logic [dpu_pkg::BACK_WORDS-1:0]  back_vld_q;
	dpu_pkg::word_t                  main_rd_s1;
	dpu_pkg::word_t                  back_rd_s1;
	logic                            main_vld_s1;
	logic                            back_vld_s1;

	// page copy pipeline: each word is written in the cycle after its read is issued
	logic                    cp_pend_s1;
	logic                    cp_load_s1;
	dpu_pkg::baddr_t         cp_wa_s1;

	logic                    main_re, main_we, back_re, back_we;
	dpu_pkg::maddr_t         main_ra, main_wa;
	dpu_pkg::baddr_t         back_ra, back_wa;
	dpu_pkg::word_t          main_wd, back_wd;
	dpu_pkg::word_t          main_dout, back_dout;

	logic                    copy_run;
	logic                    has_free;
	dpu_pkg::frame_t         free_fr;
	dpu_pkg::frame_t         lru_fr;
	dpu_pkg::frame_t         victim_fr;
	logic                    vic_hit;
	dpu_pkg::page_t          vic_page;
	logic [dpu_pkg::FRAMES-1:0] taken;
	logic                    lru_found;

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign read_value = read_value_q;
	assign page_fault = page_fault_q;

	assign main_dout = main_vld_s1 ? main_rd_s1 : '1;
	assign back_dout = back_vld_s1 ? back_rd_s1 : '1;
	assign copy_run  = (cnt_q < dpu_pkg::cnt_t'(dpu_pkg::PAGE_WORDS));

	// free frame and victim selection
	always_comb begin
		taken     = '0;
		has_free  = 1'b0;
		free_fr   = '0;
		lru_fr    = '0;
		lru_found = 1'b0;
		vic_hit   = 1'b0;
		vic_page  = '0;
		for (int p = 0; p < dpu_pkg::VPAGES; p++) begin
			if (entry_valid_q[p])
				taken[entry_frame_q[p]] = 1'b1;
		end
		for (int f = dpu_pkg::FRAMES - 1; f >= 0; f--) begin
			if (!taken[f]) begin
				has_free = 1'b1;
				free_fr  = dpu_pkg::frame_t'(f);
			end
		end
		for (int f = 0; f < dpu_pkg::FRAMES; f++) begin
			if (frame_used_q[f] && (!lru_found || frame_age_q[f] > frame_age_q[lru_fr])) begin
				lru_fr    = dpu_pkg::frame_t'(f);
				lru_found = 1'b1;
			end
		end
		victim_fr = (policy_q == dpu_pkg::POLICY_LRU) ? lru_fr : fifo_ptr_q;
		for (int p = dpu_pkg::VPAGES - 1; p >= 0; p--) begin
			if (entry_valid_q[p] && entry_frame_q[p] == victim_fr) begin
				vic_hit  = 1'b1;
				vic_page = dpu_pkg::page_t'(p);
			end
		end
	end

	// memory port steering
	always_comb begin
		main_re = 1'b0;
		main_ra = '0;
		main_we = 1'b0;
		main_wa = '0;
		main_wd = wdata_q;
		back_re = 1'b0;
		back_ra = '0;
		back_we = 1'b0;
		back_wa = '0;
		back_wd = main_dout;
		case (state_q)
			ST_WB: begin
				main_re = copy_run;
				main_ra = {fr_q, cnt_q[dpu_pkg::OFF_W-1:0]};
			end
			ST_LOAD: begin
				back_re = copy_run;
				back_ra = {page_q, cnt_q[dpu_pkg::OFF_W-1:0]};
			end
			ST_ACCESS: begin
				if (kind_q == dpu_pkg::KIND_WRITE) begin
					main_we = 1'b1;
					main_wa = {fr_q, off_q};
				end else begin
					main_re = 1'b1;
					main_ra = {fr_q, off_q};
				end
			end
			default: ;
		endcase
		if (cp_pend_s1) begin
			if (cp_load_s1) begin
				main_we = 1'b1;
				main_wa = cp_wa_s1[dpu_pkg::MADDR_W-1:0];
				main_wd = back_dout;
			end else begin
				back_we = 1'b1;
				back_wa = cp_wa_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (main_we)
			main_mem[main_wa] <= main_wd;
		if (main_re)
			main_rd_s1 <= main_mem[main_ra];
	end

	always_ff @(posedge clk) begin
		if (back_we)
			back_mem[back_wa] <= back_wd;
		if (back_re)
			back_rd_s1 <= back_mem[back_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q  <= '0;
			back_vld_q  <= '0;
			main_vld_s1 <= 1'b0;
			back_vld_s1 <= 1'b0;
		end else begin
			if (main_we)
				main_vld_q[main_wa] <= 1'b1;
			if (back_we)
				back_vld_q[back_wa] <= 1'b1;
			if (main_re)
				main_vld_s1 <= main_vld_q[main_ra];
			if (back_re)
				back_vld_s1 <= back_vld_q[back_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			policy_q      <= dpu_pkg::POLICY_FIFO;
			kind_q        <= dpu_pkg::KIND_READ;
			page_q        <= '0;
			off_q         <= '0;
			wdata_q       <= '0;
			fr_q          <= '0;
			vp_q          <= '0;
			fault_q       <= 1'b0;
			cnt_q         <= '0;
			fifo_ptr_q    <= '0;
			entry_valid_q <= '0;
			entry_dirty_q <= '0;
			frame_used_q  <= '0;
			for (int p = 0; p < dpu_pkg::VPAGES; p++)
				entry_frame_q[p] <= '0;
			for (int f = 0; f < dpu_pkg::FRAMES; f++)
				frame_age_q[f] <= '0;
			cp_pend_s1    <= 1'b0;
			cp_load_s1    <= 1'b0;
			cp_wa_s1      <= '0;
			done_q        <= 1'b0;
			read_value_q  <= '0;
			page_fault_q  <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			cp_pend_s1 <= 1'b0;
			if (cfg_we)
				policy_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						page_q  <= virtual_address[dpu_pkg::VADDR_W-1:dpu_pkg::OFF_W];
						off_q   <= virtual_address[dpu_pkg::OFF_W-1:0];
						wdata_q <= write_value;
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					cnt_q <= '0;
					if (entry_valid_q[page_q]) begin
						fr_q    <= entry_frame_q[page_q];
						fault_q <= 1'b0;
						state_q <= ST_ACCESS;
					end else begin
						fault_q <= 1'b1;
						state_q <= ST_LOAD;
						if (has_free) begin
							fr_q <= free_fr;
						end else begin
							fr_q <= victim_fr;
							if (policy_q == dpu_pkg::POLICY_FIFO)
								fifo_ptr_q <= fifo_ptr_q + 1'b1;
							if (vic_hit) begin
								// unmap now; the copies below use vp_q, page_q and fr_q only
								entry_valid_q[vic_page] <= 1'b0;
								entry_dirty_q[vic_page] <= 1'b0;
								entry_frame_q[vic_page] <= '0;
								vp_q                    <= vic_page;
								if (entry_dirty_q[vic_page])
									state_q <= ST_WB;
							end
						end
					end
				end
				ST_WB, ST_LOAD: begin
					cp_pend_s1 <= copy_run;
					cp_load_s1 <= (state_q == ST_LOAD);
					cp_wa_s1   <= (state_q == ST_LOAD) ?
						dpu_pkg::baddr_t'({fr_q, cnt_q[dpu_pkg::OFF_W-1:0]}) :
						{vp_q, cnt_q[dpu_pkg::OFF_W-1:0]};
					if (copy_run) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						// last copy write lands on this edge
						cnt_q <= '0;
						if (state_q == ST_WB) begin
							state_q <= ST_LOAD;
						end else begin
							entry_valid_q[page_q] <= 1'b1;
							entry_dirty_q[page_q] <= 1'b0;
							entry_frame_q[page_q] <= fr_q;
							state_q               <= ST_ACCESS;
						end
					end
				end
				ST_ACCESS: begin
					for (int f = 0; f < dpu_pkg::FRAMES; f++) begin
						if (dpu_pkg::frame_t'(f) == fr_q)
							frame_age_q[f] <= '0;
						else if (frame_used_q[f] && frame_age_q[f] != '1)
							frame_age_q[f] <= frame_age_q[f] + 1'b1;
					end
					frame_used_q[fr_q] <= 1'b1;
					if (kind_q == dpu_pkg::KIND_WRITE) begin
						entry_dirty_q[page_q] <= 1'b1;
						read_value_q          <= '0;
						page_fault_q          <= fault_q;
						done_q                <= 1'b1;
						state_q               <= ST_IDLE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					read_value_q <= main_dout;
					page_fault_q <= fault_q;
					done_q       <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/dpu_checker.sv -----
`include "assert_macros.svh"

module dpu_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   done,
	input logic                   page_fault
);

	logic accept;
	assign accept = start && !busy;

	// an accepted beat occupies the unit on the next cycle
	`CHK_NEXT(a_accept_busy, clk, arst_n, accept, busy)
	// every completed beat gives exactly one result strobe
	`CHK_SAME(a_fell_done, clk, arst_n, $fell(busy), done)
	`CHK_SAME(a_done_fell, clk, arst_n, done, $fell(busy))
	// strobe is a single cycle
	`CHK_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// a fault result never follows a short hit sequence
	`CHK_SAME(a_fault_long, clk, arst_n, done && page_fault, $past(busy, 3))

endmodule

bind demand_paging_unit_core dpu_checker u_dpu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.page_fault (page_fault)
);

// ----- tb/tb_demand_paging_unit_core.sv -----
`timescale 1ns / 100ps

module tb_demand_paging_unit_core;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int IDLE_TAIL   = 24;

	typedef struct {
		dpu_pkg::word_t rd;
		logic           pf;
	} access_result_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            start = 1'b0;
	logic            busy;
	logic            kind = dpu_pkg::KIND_READ;
	dpu_pkg::vaddr_t virtual_address = '0;
	dpu_pkg::word_t  write_value = '0;
	logic            done;
	dpu_pkg::word_t  read_value;
	logic            page_fault;
	logic            cfg_we = 1'b0;
	logic            cfg_wdata = dpu_pkg::POLICY_FIFO;

	demand_paging_unit_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.virtual_address (virtual_address),
		.write_value     (write_value),
		.done            (done),
		.read_value      (read_value),
		.page_fault      (page_fault),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the paging state
	logic            pt_valid [dpu_pkg::VPAGES];
	logic            pt_dirty [dpu_pkg::VPAGES];
	dpu_pkg::frame_t pt_frame [dpu_pkg::VPAGES];
	dpu_pkg::frame_t fifo_ptr;
	logic            frm_used [dpu_pkg::FRAMES];
	dpu_pkg::frame_t frm_age  [dpu_pkg::FRAMES];
	dpu_pkg::word_t  main_mem [dpu_pkg::MAIN_WORDS];
	dpu_pkg::word_t  back_mem [dpu_pkg::BACK_WORDS];
	logic            policy;

	access_result_t pending_results[$];
	access_result_t oldest_result;
	int             err_cnt = 0;
	int             cycle_cnt = 0;

	initial begin
		for (int p = 0; p < dpu_pkg::VPAGES; p++) begin
			pt_valid[p] = 1'b0;
			pt_dirty[p] = 1'b0;
			pt_frame[p] = '0;
		end
		for (int f = 0; f < dpu_pkg::FRAMES; f++) begin
			frm_used[f] = 1'b0;
			frm_age[f]  = '0;
		end
		for (int i = 0; i < dpu_pkg::MAIN_WORDS; i++) main_mem[i] = '1;
		for (int i = 0; i < dpu_pkg::BACK_WORDS; i++) back_mem[i] = '1;
		fifo_ptr = '0;
		policy   = dpu_pkg::POLICY_FIFO;
	end

	task automatic paging_access(input logic k, input dpu_pkg::vaddr_t va,
			input dpu_pkg::word_t wd, output dpu_pkg::word_t rd, output logic pf);
		dpu_pkg::page_t  pg;
		dpu_pkg::off_t   off;
		dpu_pkg::frame_t fr;
		logic            found;
		logic            unmapped;
		logic            taken [dpu_pkg::FRAMES];
		int              best;
		pg  = va[dpu_pkg::VADDR_W-1:dpu_pkg::OFF_W];
		off = va[dpu_pkg::OFF_W-1:0];
		rd  = '0;
		pf  = 1'b0;
		fr  = '0;
		if (pt_valid[pg]) begin
			fr = pt_frame[pg];
		end else begin
			pf = 1'b1;
			for (int f = 0; f < dpu_pkg::FRAMES; f++) taken[f] = 1'b0;
			for (int p = 0; p < dpu_pkg::VPAGES; p++)
				if (pt_valid[p]) taken[pt_frame[p]] = 1'b1;
			found = 1'b0;
			for (int f = 0; f < dpu_pkg::FRAMES; f++) begin
				if (!found && !taken[f]) begin
					fr    = dpu_pkg::frame_t'(f);
					found = 1'b1;
				end
			end
			if (!found) begin
				if (policy == dpu_pkg::POLICY_FIFO) begin
					fr       = fifo_ptr;
					fifo_ptr = (int'(fifo_ptr) == dpu_pkg::FRAMES - 1) ? '0 : fifo_ptr + 1'b1;
				end else begin
					// oldest used frame, lowest index wins a tie
					best  = 0;
					found = 1'b0;
					for (int f = 0; f < dpu_pkg::FRAMES; f++) begin
						if (frm_used[f] && (!found || frm_age[f] > frm_age[best])) begin
							best  = f;
							found = 1'b1;
						end
					end
					fr = dpu_pkg::frame_t'(best);
				end
				unmapped = 1'b0;
				for (int p = 0; p < dpu_pkg::VPAGES; p++) begin
					if (!unmapped && pt_valid[p] && pt_frame[p] == fr) begin
						if (pt_dirty[p])
							for (int i = 0; i < dpu_pkg::PAGE_WORDS; i++)
								back_mem[p * dpu_pkg::PAGE_WORDS + i] =
									main_mem[int'(fr) * dpu_pkg::PAGE_WORDS + i];
						pt_valid[p] = 1'b0;
						pt_dirty[p] = 1'b0;
						pt_frame[p] = '0;
						unmapped    = 1'b1;
					end
				end
			end
			for (int i = 0; i < dpu_pkg::PAGE_WORDS; i++)
				main_mem[int'(fr) * dpu_pkg::PAGE_WORDS + i] =
					back_mem[int'(pg) * dpu_pkg::PAGE_WORDS + i];
			pt_valid[pg] = 1'b1;
			pt_dirty[pg] = 1'b0;
			pt_frame[pg] = fr;
		end
		if (k == dpu_pkg::KIND_WRITE) begin
			main_mem[int'(fr) * dpu_pkg::PAGE_WORDS + int'(off)] = wd;
			pt_dirty[pg] = 1'b1;
		end else begin
			rd = main_mem[int'(fr) * dpu_pkg::PAGE_WORDS + int'(off)];
		end
		for (int f = 0; f < dpu_pkg::FRAMES; f++)
			if (f != int'(fr) && frm_used[f] && int'(frm_age[f]) < dpu_pkg::FRAMES - 1)
				frm_age[f] = frm_age[f] + 1'b1;
		frm_used[fr] = 1'b1;
		frm_age[fr]  = '0;
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(input bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_beat(input logic k, input dpu_pkg::vaddr_t va,
			input dpu_pkg::word_t wd, input int gap);
		dpu_pkg::word_t rd;
		logic           pf;
		access_result_t r;
		start           <= 1'b1;
		kind            <= k;
		virtual_address <= va;
		write_value     <= wd;
		@(posedge clk);
		while (busy) @(posedge clk);
		paging_access(k, va, wd, rd, pf);
		r.rd = rd;
		r.pf = pf;
		pending_results.push_back(r);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic set_policy(input logic p);
		cfg_we    <= 1'b1;
		cfg_wdata <= p;
		@(posedge clk);
		cfg_we <= 1'b0;
		policy = p;
	endtask

	// reset-value reads, data extremes, fill, dirty and clean FIFO evictions
	task automatic test_fifo_directed();
		send_beat(dpu_pkg::KIND_READ,  6'd0,  $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd63, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_WRITE, 6'd0,  32'sh8000_0000, pick_gap(0));
		send_beat(dpu_pkg::KIND_WRITE, 6'd63, 32'sh7fff_ffff, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd0,  '0, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd63, '1, pick_gap(0));
		send_beat(dpu_pkg::KIND_WRITE, 6'd21, '0, pick_gap(0));   // write fault
		send_beat(dpu_pkg::KIND_READ,  6'd21, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd24, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd32, $urandom, pick_gap(0)); // dirty victim
		send_beat(dpu_pkg::KIND_READ,  6'd0,  $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd63, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_WRITE, 6'd40, 32'sd1, pick_gap(0));   // clean victim
		send_beat(dpu_pkg::KIND_READ,  6'd21, $urandom, 0);
		wait_idle();
	endtask

	// LRU order, saturated ages with lowest-index tie break
	task automatic test_lru_directed();
		set_policy(dpu_pkg::POLICY_LRU);
		send_beat(dpu_pkg::KIND_WRITE, 6'd8,  32'sh1234_5678, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd63, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd0,  $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd40, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd48, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd48, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd49, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd50, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_WRITE, 6'd51, -32'sd1, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd16, $urandom, pick_gap(0));
		send_beat(dpu_pkg::KIND_READ,  6'd8,  $urandom, 0);
		wait_idle();
	endtask

	task automatic test_random_traffic(input logic p, input int n, input bit no_idle);
		int              base;
		int              span;
		int              pg;
		logic            k;
		dpu_pkg::word_t  wd;
		dpu_pkg::vaddr_t va;
		set_policy(p);
		base = $urandom_range(0, dpu_pkg::VPAGES - 1);
		span = $urandom_range(3, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 5) begin
				base = $urandom_range(0, dpu_pkg::VPAGES - 1);
				span = $urandom_range(3, 6);
			end
			if ($urandom_range(0, 99) < 80)
				pg = (base + $urandom_range(0, span - 1)) % dpu_pkg::VPAGES;
			else
				pg = $urandom_range(0, dpu_pkg::VPAGES - 1);
			va = {dpu_pkg::page_t'(pg),
				dpu_pkg::off_t'($urandom_range(0, dpu_pkg::PAGE_WORDS - 1))};
			k  = logic'($urandom_range(0, 1));
			case ($urandom_range(0, 19))
				0: wd = '0;
				1: wd = '1;
				2: wd = 32'sh8000_0000;
				3: wd = 32'sh7fff_ffff;
				default: wd = $urandom;
			endcase
			send_beat(k, va, wd, pick_gap(no_idle));
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result read_value %h page_fault %b",
					$time, read_value, page_fault);
				err_cnt++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (read_value !== oldest_result.rd) begin
					$display("%0t: read_value expected %h actual %h",
						$time, oldest_result.rd, read_value);
					err_cnt++;
				end
				if (page_fault !== oldest_result.pf) begin
					$display("%0t: page_fault expected %b actual %b",
						$time, oldest_result.pf, page_fault);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fifo_directed();
		test_lru_directed();
		test_random_traffic(dpu_pkg::POLICY_FIFO, 200, 1'b0);
		test_random_traffic(dpu_pkg::POLICY_LRU,  200, 1'b0);
		test_random_traffic(dpu_pkg::POLICY_FIFO, 150, 1'b1);
		test_random_traffic(dpu_pkg::POLICY_LRU,  200, 1'b0);
		test_random_traffic(dpu_pkg::POLICY_LRU,  150, 1'b1);
		test_random_traffic(dpu_pkg::POLICY_FIFO, 250, 1'b0);
		if (err_cnt == 0 && pending_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
